// ===== src/tip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text-to-integer parser package
// Shared types, character codes and helper functions of the parser blocks.
// ----------------------------------------------------------------------------
package tip_pkg;

    localparam int CH_W     = 8;
    localparam int BASE_W   = 6;
    localparam int VALUE_W  = 64;
    localparam int END_W    = 16;
    localparam int DIGIT_W  = 7;
    localparam int MUL_W    = VALUE_W + BASE_W;

    localparam logic [VALUE_W-1:0] MAG_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd64;

    localparam logic [BASE_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_W-1:0] BASE_RESET  = BASE_DEC;

    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

    // One accepted character
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            start_req;
    } t_item;

    // One finished conversion
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [END_W-1:0]   end_offset;
        logic               converted;
        logic               overflow;
    } t_result;

    // Space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Digit value 0..35, or DIGIT_NONE for a non-alphanumeric byte
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = DIGIT_W'(c - CH_LO_A) + 7'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = DIGIT_W'(c - CH_UP_A) + 7'd10;
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== src/tip_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parser step
// Holds the per-string parse state and advances it by one character a cycle while i_fire is high.
// ----------------------------------------------------------------------------
module tip_step #(
    parameter int OFFSET_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_fire,
    input  wire tip_pkg::t_item         i_item,
    input  wire [tip_pkg::BASE_W-1:0]   i_number_base,
    output logic                        o_emit,
    output tip_pkg::t_result            o_result
);

    typedef enum logic [4:0] {
        PH_DONE   = 5'b00001,
        PH_LEAD   = 5'b00010,
        PH_SIGNED = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } t_phase;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    t_phase                          r_phase,    n_phase;
    logic                            r_negative, n_negative;
    logic [tip_pkg::BASE_W-1:0]      r_base,     n_base;
    logic [tip_pkg::VALUE_W-1:0]     r_mag,      n_mag;
    logic                            r_any,      n_any;
    logic [OFFSET_BITS-1:0]          r_pos,      n_pos;
    logic                            r_sat,      n_sat;

    logic                            live;
    logic                            run_digit;
    logic [tip_pkg::DIGIT_W-1:0]     dig;
    logic [tip_pkg::MUL_W-1:0]       mac;
    logic [OFFSET_BITS+tip_pkg::END_W-1:0] pos_ext;

    assign dig = tip_pkg::digit_of(i_item.ch);

    // Advance the parse state for one character
    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_base     = r_base;
        n_mag      = r_mag;
        n_any      = r_any;
        n_pos      = r_pos;
        n_sat      = r_sat;
        live       = 1'b0;
        run_digit  = 1'b0;
        mac        = '0;
        pos_ext    = '0;
        o_emit     = 1'b0;
        o_result   = '0;

        if (i_fire) begin
            // restart or count the character
            if (i_item.start_req) begin
                n_phase    = PH_LEAD;
                n_negative = 1'b0;
                n_base     = i_number_base;
                n_mag      = '0;
                n_any      = 1'b0;
                n_pos      = '0;
                n_sat      = 1'b0;
                live       = 1'b1;
            end else if (r_phase != PH_DONE) begin
                live = 1'b1;
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end

            if (live) begin
                unique case (n_phase)
                    PH_LEAD, PH_SIGNED: begin
                        if (n_phase == PH_LEAD && tip_pkg::is_blank(i_item.ch)) begin
                            n_phase = PH_LEAD;
                        end else if (n_phase == PH_LEAD &&
                                     (i_item.ch == tip_pkg::CH_MINUS ||
                                      i_item.ch == tip_pkg::CH_PLUS)) begin
                            n_negative = (i_item.ch == tip_pkg::CH_MINUS);
                            n_phase    = PH_SIGNED;
                        end else if ((n_base == tip_pkg::BASE_AUTO ||
                                      n_base == tip_pkg::BASE_HEX) &&
                                     i_item.ch == tip_pkg::CH_ZERO) begin
                            n_phase = PH_ZERO;
                        end else begin
                            if (n_base == tip_pkg::BASE_AUTO) begin
                                n_base = tip_pkg::BASE_DEC;
                            end
                            run_digit = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (i_item.ch == tip_pkg::CH_LO_X || i_item.ch == tip_pkg::CH_UP_X) begin
                            n_base  = tip_pkg::BASE_HEX;
                            n_phase = PH_DIGITS;
                        end else begin
                            // leading zero is a digit in hex, the octal prefix otherwise
                            if (n_base == tip_pkg::BASE_HEX) begin
                                n_any = 1'b1;
                            end else begin
                                n_base = tip_pkg::BASE_OCT;
                            end
                            run_digit = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        run_digit = 1'b1;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end

            // accumulate a digit or close the string
            if (run_digit) begin
                if (dig >= {1'b0, n_base}) begin
                    o_emit  = 1'b1;
                    n_phase = PH_DONE;
                    pos_ext = {{tip_pkg::END_W{1'b0}}, n_pos};
                    o_result.value      = n_negative ? (~n_mag + 1'b1) : n_mag;
                    o_result.end_offset = n_any ? pos_ext[tip_pkg::END_W-1:0] : '0;
                    o_result.converted  = n_any;
                    o_result.overflow   = n_any && n_sat;
                end else begin
                    mac = tip_pkg::MUL_W'(n_mag) * tip_pkg::MUL_W'(n_base)
                        + tip_pkg::MUL_W'(dig);
                    if (n_sat || n_base == '0 ||
                        mac > tip_pkg::MUL_W'(tip_pkg::MAG_LIMIT)) begin
                        n_mag = tip_pkg::MAG_LIMIT;
                        n_sat = 1'b1;
                    end else begin
                        n_mag = mac[tip_pkg::VALUE_W-1:0];
                    end
                    n_any   = 1'b1;
                    n_phase = PH_DIGITS;
                end
            end
        end
    end

    // Hold the parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DONE;
            r_negative <= 1'b0;
            r_base     <= '0;
            r_mag      <= '0;
            r_any      <= 1'b0;
            r_pos      <= '0;
            r_sat      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_base     <= n_base;
            r_mag      <= n_mag;
            r_any      <= n_any;
            r_pos      <= n_pos;
            r_sat      <= n_sat;
        end
    end

endmodule
`default_nettype wire

// ===== src/text_to_integer_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text-to-integer parser core
// Converts a character stream into signed integers, strtol style.
// ----------------------------------------------------------------------------
//  channel   direction  transfer carries
//  s_axis    in         one character (tdata), string start flag (tuser)
//  m_axis    out        value and end offset (tdata), converted/overflow (tuser)
//  cfg       in         number base, 0 = automatic detection
//
// One character a cycle while the result register is not stalled: a character
// waits in the input register, then a single pass through the step logic
// (one 64x6 multiply-add) updates the parse state and, at the end of a string,
// loads the result register, which drives the result stream.
// Reset is synchronous, active low; the base returns to decimal.
// A stalled result register holds the input register, which then drops ready.
// ----------------------------------------------------------------------------
module text_to_integer_parser_core #(
    parameter int OFFSET_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // character stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire         i_s_axis_tuser,   // [0] start_req
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [63:0] value, [79:64] end_offset
    output logic [1:0]  o_m_axis_tuser,   // [0] converted, [1] overflow
    // base register
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [5:0]  i_cfg_data        // [5:0] number_base
);

    logic                        r_in_valid;
    tip_pkg::t_item              r_in;
    logic [tip_pkg::BASE_W-1:0]  r_number_base;
    logic                        r_out_valid;
    tip_pkg::t_result            r_out;

    logic                        consume;
    logic                        emit;
    tip_pkg::t_result            result;

    assign consume         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || consume;
    assign o_cfg_ready     = 1'b1;

    // Base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= tip_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            r_number_base <= i_cfg_data;
        end
    end

    // Input register: load on transfer, drop when consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.ch        <= i_s_axis_tdata;
            r_in.start_req <= i_s_axis_tuser;
        end
    end

    tip_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (consume),
        .i_item        (r_in),
        .i_number_base (r_number_base),
        .o_emit        (emit),
        .o_result      (result)
    );

    // Result register: load on end of string, clear on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.end_offset, r_out.value};
    assign o_m_axis_tuser  = {r_out.overflow, r_out.converted};

endmodule
`default_nettype wire

// ===== verif/tb_text_to_integer_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the text-to-integer parser core
// Streams strings into the core one character per transfer and predicts every
// result with an independent parser model kept in step with the accepted
// characters. A short table of hand-picked strings runs first, then random
// strings over many bases with bursty input, a stalling result side and
// repeated long result hold-offs.
// ----------------------------------------------------------------------------
module tb_text_to_integer_parser_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_CHARS   = 1500;

    typedef enum logic [2:0] {PH_IDLE, PH_LEAD, PH_SIGN, PH_ZERO, PH_DIGIT} t_parse_phase;

    // One row of the directed table; want is used only when fixed is set
    typedef struct {
        logic [tip_pkg::BASE_W-1:0] base;
        logic [tip_pkg::CH_W-1:0]   ch;
        logic                       start;
        bit                         fixed;
        tip_pkg::t_result           want;
    } t_stim_row;

    logic        i_clk;
    logic        rst_n;
    logic        s_tvalid;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tready;
    logic        cfg_valid;
    logic [5:0]  cfg_data;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [79:0] o_m_axis_tdata;
    wire  [1:0]  o_m_axis_tuser;
    wire         o_cfg_ready;

    // Parser model state
    t_parse_phase               ps_phase = PH_IDLE;
    logic                       ps_neg   = 1'b0;
    logic [tip_pkg::BASE_W-1:0] ps_base  = '0;
    logic [63:0]                ps_mag   = '0;
    logic                       ps_any   = 1'b0;
    logic [15:0]                ps_pos   = '0;
    logic                       ps_sat   = 1'b0;
    logic [tip_pkg::BASE_W-1:0] cfg_base = tip_pkg::BASE_RESET;

    tip_pkg::t_result pending_results[$];
    t_stim_row        directed_rows[$];

    int  mismatches     = 0;
    int  results_seen   = 0;
    int  converted_seen = 0;
    int  saturated_seen = 0;
    int  parsed_chars   = 0;
    int  base_writes    = 0;
    int  hold_offs      = 0;
    int  burst_left     = 0;
    bit  dense          = 1'b0;
    bit  hold_req       = 1'b0;

    text_to_integer_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] ch
        .i_s_axis_tuser  (s_tuser),    // [0] start_req
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [63:0] value, [79:64] end_offset
        .o_m_axis_tuser  (o_m_axis_tuser),  // [0] converted, [1] overflow
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)         // [5:0] number_base
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Value of an alphanumeric character, 64 for anything else
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= tip_pkg::CH_ZERO && c <= tip_pkg::CH_NINE) begin
            v = 7'(c - tip_pkg::CH_ZERO);
        end else if (c >= tip_pkg::CH_LO_A && c <= tip_pkg::CH_LO_Z) begin
            v = 7'(c - tip_pkg::CH_LO_A) + 7'd10;
        end else if (c >= tip_pkg::CH_UP_A && c <= tip_pkg::CH_UP_Z) begin
            v = 7'(c - tip_pkg::CH_UP_A) + 7'd10;
        end
        return v;
    endfunction

    // Multiply-add one digit, pinning the magnitude at the limit once exceeded
    function automatic void accumulate(input logic [6:0] d);
        logic [69:0] wide;
        wide = 70'(ps_mag) * 70'(ps_base) + 70'(d);
        if (!ps_sat && ps_base != '0 && wide <= 70'(tip_pkg::MAG_LIMIT)) begin
            ps_mag = wide[63:0];
        end else begin
            ps_mag = tip_pkg::MAG_LIMIT;
            ps_sat = 1'b1;
        end
        ps_any = 1'b1;
    endfunction

    function automatic tip_pkg::t_result close_string();
        tip_pkg::t_result r;
        r.value      = ps_neg ? -ps_mag : ps_mag;
        r.end_offset = ps_any ? ps_pos : '0;
        r.converted  = ps_any;
        r.overflow   = ps_any & ps_sat;
        ps_phase     = PH_IDLE;
        return r;
    endfunction

    // Take a digit, or end the string on the first character that does not fit
    function automatic bit take_digit(input logic [7:0] c, output tip_pkg::t_result r);
        logic [6:0] d;
        d = char_value(c);
        r = '0;
        if (d >= {1'b0, ps_base}) begin
            r = close_string();
            return 1'b1;
        end
        accumulate(d);
        ps_phase = PH_DIGIT;
        return 1'b0;
    endfunction

    // First character after blanks and sign: may open a radix prefix
    function automatic bit first_digit(input logic [7:0] c, output tip_pkg::t_result r);
        r = '0;
        if ((ps_base == tip_pkg::BASE_AUTO || ps_base == tip_pkg::BASE_HEX) &&
            c == tip_pkg::CH_ZERO) begin
            ps_phase = PH_ZERO;
            return 1'b0;
        end
        if (ps_base == tip_pkg::BASE_AUTO) ps_base = tip_pkg::BASE_DEC;
        return take_digit(c, r);
    endfunction

    // Advance the model by one accepted character; returns 1 with a result
    function automatic bit parse_char(input logic [7:0] c, input logic st,
                                      output tip_pkg::t_result r);
        r = '0;
        if (st) begin
            ps_phase = PH_LEAD;
            ps_neg   = 1'b0;
            ps_base  = cfg_base;
            ps_mag   = '0;
            ps_any   = 1'b0;
            ps_pos   = '0;
            ps_sat   = 1'b0;
        end else begin
            if (ps_phase == PH_IDLE) return 1'b0;
            if (ps_pos != '1) ps_pos++;
        end
        case (ps_phase)
            PH_LEAD: begin
                if (c == tip_pkg::CH_SPACE ||
                    (c >= tip_pkg::CH_TAB && c <= tip_pkg::CH_CR)) return 1'b0;
                if (c == tip_pkg::CH_MINUS || c == tip_pkg::CH_PLUS) begin
                    ps_neg   = (c == tip_pkg::CH_MINUS);
                    ps_phase = PH_SIGN;
                    return 1'b0;
                end
                return first_digit(c, r);
            end
            PH_SIGN: begin
                return first_digit(c, r);
            end
            PH_ZERO: begin
                if (c == tip_pkg::CH_LO_X || c == tip_pkg::CH_UP_X) begin
                    ps_base  = tip_pkg::BASE_HEX;
                    ps_phase = PH_DIGIT;
                    return 1'b0;
                end
                // a lone zero is a digit in hex, the octal prefix in auto mode
                if (ps_base == tip_pkg::BASE_HEX) accumulate(7'd0);
                else ps_base = tip_pkg::BASE_OCT;
                return take_digit(c, r);
            end
            PH_DIGIT: begin
                return take_digit(c, r);
            end
            default: begin
                ps_phase = PH_IDLE;
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one character, wait for the transfer, record what it should yield
    task automatic send_char(input logic [7:0] c, input logic st, input bit fixed,
                             input tip_pkg::t_result fixed_res);
        tip_pkg::t_result r;
        s_tdata  <= c;
        s_tuser  <= st;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        if (st || ps_phase != PH_IDLE) parsed_chars++;
        if (parse_char(c, st, r)) pending_results.push_back(fixed ? fixed_res : r);
    endtask

    // Random character with burst pacing
    task automatic send_paced(input logic [7:0] c, input logic st);
        int gap;
        send_char(c, st, 1'b0, '0);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = dense ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid, wait out every pending result and the core's pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [5:0] b);
        settle();
        cfg_data  <= b;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        cfg_base = b;
        base_writes++;
    endtask

    // One random string: mostly well formed, some truncated, some noise
    task automatic send_string(input logic [5:0] b);
        logic [7:0] text[$];
        int kind, n, lim, k, d;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                send_paced(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 7) == 0);
            end
            return;
        end
        // leading blanks
        n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        repeat (n) begin
            k = $urandom_range(0, 5);
            text.push_back(k == 5 ? tip_pkg::CH_SPACE : 8'(tip_pkg::CH_TAB + k));
        end
        k = $urandom_range(0, 3);
        if (k == 0) text.push_back(tip_pkg::CH_MINUS);
        else if (k == 1) text.push_back(tip_pkg::CH_PLUS);
        // radix prefix where the base allows one
        lim = (b > 36) ? 36 : b;
        if (b == tip_pkg::BASE_AUTO || b == tip_pkg::BASE_HEX) begin
            k = $urandom_range(0, 2);
            if (k == 0) begin
                text.push_back(tip_pkg::CH_ZERO);
                text.push_back($urandom_range(0, 1) ? tip_pkg::CH_LO_X : tip_pkg::CH_UP_X);
                lim = 16;
            end else if (k == 1 && b == tip_pkg::BASE_AUTO) begin
                text.push_back(tip_pkg::CH_ZERO);
                lim = 8;
            end else if (b == tip_pkg::BASE_AUTO) begin
                lim = 10;
            end
        end
        // digits, now and then long enough to saturate
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 8);
        repeat (n) begin
            d = $urandom_range(0, lim - 1);
            text.push_back(d < 10 ? 8'(tip_pkg::CH_ZERO + d)
                                  : 8'(($urandom_range(0, 1) ? tip_pkg::CH_LO_A
                                                             : tip_pkg::CH_UP_A) + d - 10));
        end
        // a truncated string is abandoned by the next start
        if (kind != 1) text.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        if (kind == 2) begin
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
        end
        if (text.size() == 0) text.push_back(8'h00);
        foreach (text[i]) send_paced(text[i], i == 0);
    endtask

    function automatic void add_row(input logic [5:0] b, input logic [7:0] c, input logic st,
                                    input bit fx = 1'b0, input logic [63:0] v = '0,
                                    input logic [15:0] off = '0, input logic conv = 1'b0,
                                    input logic ovf = 1'b0);
        t_stim_row row;
        row.base  = b;
        row.ch    = c;
        row.start = st;
        row.fixed = fx;
        row.want.value      = v;
        row.want.end_offset = off;
        row.want.converted  = conv;
        row.want.overflow   = ovf;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h (result %0d, t=%0t)",
                 field, got, want, results_seen, $realtime);
        mismatches++;
    endtask

    // Ready pattern: segments of full, random, sparse and periodic ready,
    // with a long hold-off when requested
    initial begin
        int seg_left, mode, tick;
        bit rdy;
        seg_left = 0;
        mode     = 0;
        tick     = 0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_offs++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 160);
            end
            seg_left--;
            tick++;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ((tick / 3) % 2 == 0);
            endcase
            m_tready <= rdy;
            @(posedge i_clk);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        tip_pkg::t_result want;
        if (rst_n && o_m_axis_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[63:0] !== want.value)
                    report_mismatch("value", o_m_axis_tdata[63:0], want.value);
                if (o_m_axis_tdata[79:64] !== want.end_offset)
                    report_mismatch("end_offset", 64'(o_m_axis_tdata[79:64]),
                                    64'(want.end_offset));
                if (o_m_axis_tuser[0] !== want.converted)
                    report_mismatch("converted", 64'(o_m_axis_tuser[0]),
                                    64'(want.converted));
                if (o_m_axis_tuser[1] !== want.overflow)
                    report_mismatch("overflow", 64'(o_m_axis_tuser[1]),
                                    64'(want.overflow));
                if (want.converted) converted_seen++;
                if (want.overflow) saturated_seen++;
            end
            results_seen++;
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_axis_tready === 1'b1) ||
                (o_m_axis_tvalid === 1'b1 && m_tready) ||
                (cfg_valid && o_cfg_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog expired with %0d results outstanding", pending_results.size());
        $display("text_to_integer_parser_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int      phase_idx, target, directed_chars;
        logic [5:0] b;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Decimal after reset: blanks, sign, top byte as terminator
        add_row(tip_pkg::BASE_DEC, tip_pkg::CH_TAB,   1'b1);
        add_row(tip_pkg::BASE_DEC, tip_pkg::CH_MINUS, 1'b0);
        add_row(tip_pkg::BASE_DEC, "7",               1'b0);
        add_row(tip_pkg::BASE_DEC, 8'hFF, 1'b0, 1'b1, -64'd7, 16'd3, 1'b1, 1'b0);
        // ignored after the end, then a start that abandons a signed string
        add_row(tip_pkg::BASE_DEC, "5",              1'b0);
        add_row(tip_pkg::BASE_DEC, tip_pkg::CH_PLUS, 1'b1);
        add_row(tip_pkg::BASE_DEC, "9",              1'b1);
        add_row(tip_pkg::BASE_DEC, 8'h00, 1'b0, 1'b1, 64'd9, 16'd1, 1'b1, 1'b0);
        // auto base: a lone zero and a bare hex prefix convert nothing
        add_row(tip_pkg::BASE_AUTO, tip_pkg::CH_ZERO, 1'b1);
        add_row(tip_pkg::BASE_AUTO, 8'h00,            1'b0, 1'b1);
        add_row(tip_pkg::BASE_AUTO, tip_pkg::CH_ZERO, 1'b1);
        add_row(tip_pkg::BASE_AUTO, tip_pkg::CH_UP_X, 1'b0);
        add_row(tip_pkg::BASE_AUTO, "g",              1'b0, 1'b1);
        // auto base: leading zero selects octal, so 8 ends the string
        add_row(tip_pkg::BASE_AUTO, tip_pkg::CH_ZERO, 1'b1);
        add_row(tip_pkg::BASE_AUTO, "7",              1'b0);
        add_row(tip_pkg::BASE_AUTO, "8", 1'b0, 1'b1, 64'd7, 16'd2, 1'b1, 1'b0);
        // hex: a lone zero is a digit
        add_row(tip_pkg::BASE_HEX, tip_pkg::CH_ZERO, 1'b1);
        add_row(tip_pkg::BASE_HEX, 8'h00, 1'b0, 1'b1, 64'd0, 16'd1, 1'b1, 1'b0);
        // widest base, negative, saturates at minus the magnitude limit
        add_row(6'd63, tip_pkg::CH_MINUS, 1'b1);
        repeat (11) add_row(6'd63, tip_pkg::CH_LO_Z, 1'b0);
        add_row(6'd63, 8'h00, 1'b0, 1'b1, 64'h8000_0000_0000_0001, 16'd12, 1'b1, 1'b1);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].start && directed_rows[i].base != cfg_base)
                write_base(directed_rows[i].base);
            send_char(directed_rows[i].ch, directed_rows[i].start,
                      directed_rows[i].fixed, directed_rows[i].want);
        end
        directed_chars = parsed_chars;

        // Random strings, one base per phase
        target    = parsed_chars + RANDOM_CHARS;
        phase_idx = 0;
        while (parsed_chars < target) begin
            case (phase_idx)
                0: b = tip_pkg::BASE_AUTO;
                1: b = 6'd63;
                2: b = 6'd1;
                3: b = tip_pkg::BASE_HEX;
                4: b = 6'd36;
                5: b = tip_pkg::BASE_OCT;
                6: b = 6'd2;
                7: b = 6'd37;
                8: b = tip_pkg::BASE_DEC;
                9: b = tip_pkg::BASE_AUTO;
                default: b = 6'($urandom_range(0, 63));
            endcase
            write_base(b);
            dense = ($urandom_range(0, 3) == 0);
            if (phase_idx % 4 == 1) hold_req = 1'b1;
            k_loop: begin
                int stop_at;
                stop_at = parsed_chars + $urandom_range(60, 140);
                while (parsed_chars < stop_at && parsed_chars < target) send_string(b);
            end
            phase_idx++;
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d characters (%0d directed) over %0d base settings",
                 parsed_chars, directed_chars, base_writes);
        $display("Checked %0d results: %0d converted, %0d saturated, %0d long hold-offs",
                 results_seen, converted_seen, saturated_seen, hold_offs);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("text_to_integer_parser_core verification clean");
        end else begin
            $display("text_to_integer_parser_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tip_pkg.sv
src/tip_step.sv
src/text_to_integer_parser_core.sv
verif/tb_text_to_integer_parser_core.sv
